// ----- design/smm_pkg.sv -----
// Shared types and constants for the square matrix multiplier.
`timescale 1ns / 1ps
`default_nettype none
package smm_pkg;

  localparam int MAX_SIZE_DEF = 8;   // largest matrix dimension
  localparam int IDX_W        = 3;   // row and column index width
  localparam int SIZE_W       = 4;   // size register width
  localparam int ELEM_W       = 16;  // Q8.8 element
  localparam int PROD_W       = 32;  // Q16.16 product
  localparam int ACC_W        = 48;  // Q32.16 accumulator
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 56;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } op_e;

  // Tags that follow one multiply-accumulate step down the pipeline.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             last_pos;
    logic             last;
  } tag_t;

  // Read issue from the controller.
  typedef struct packed {
    logic             issue;
    logic [IDX_W-1:0] pos;
    tag_t             tag;
  } cmd_t;

  // Store write from the controller.
  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  pos;
    logic [ELEM_W-1:0] value;
  } load_t;

endpackage
`default_nettype wire

// ----- design/smm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- design/smm_ctrl.sv -----
// Controller: input decode, size register and the row/column/position sequencer.
`timescale 1ns / 1ps
`default_nettype none
module smm_ctrl #(
  parameter int MAX_SIZE = smm_pkg::MAX_SIZE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [smm_pkg::IN_DATA_W-1:0] in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [smm_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  wire logic                          advance_i,
  output smm_pkg::cmd_t                      cmd_o,
  output smm_pkg::load_t                     load_o,
  output logic [smm_pkg::SIZE_W-1:0]         size_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [smm_pkg::SIZE_W-1:0] MaxN = smm_pkg::SIZE_W'(MAX_SIZE);

  logic                          state_q, state_d;
  logic [smm_pkg::SIZE_W-1:0]    size_q, size_d;
  logic [smm_pkg::IDX_W-1:0]     row_q, row_d, col_q, col_d, pos_q, pos_d;
  logic [smm_pkg::SIZE_W-1:0]    last_idx;
  logic                          row_end, col_end, pos_end, accept, in_range;
  smm_pkg::op_e                  op;
  logic [smm_pkg::IDX_W-1:0]     in_row, in_pos;

  assign op       = smm_pkg::op_e'(in_data_i[1:0]);
  assign in_row   = in_data_i[4:2];
  assign in_pos   = in_data_i[7:5];
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept   = in_valid_i && in_ready_o;
  assign in_range = ({1'b0, in_row} < MaxN) && ({1'b0, in_pos} < MaxN);
  assign size_o   = size_q;

  assign last_idx = size_q - smm_pkg::SIZE_W'(1);
  assign pos_end  = ({1'b0, pos_q} == last_idx);
  assign col_end  = ({1'b0, col_q} == last_idx);
  assign row_end  = ({1'b0, row_q} == last_idx);

  // A written size of zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    size_d = size_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        size_d = smm_pkg::SIZE_W'(1);
      end else if (cfg_wdata_i > MaxN) begin
        size_d = MaxN;
      end else begin
        size_d = cfg_wdata_i;
      end
    end
  end

  always_comb begin
    load_o       = '0;
    load_o.row   = in_row;
    load_o.pos   = in_pos;
    load_o.value = in_data_i[23:8];
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    pos_d        = pos_q;
    cmd_o              = '0;
    cmd_o.pos          = pos_q;
    cmd_o.tag.row      = row_q;
    cmd_o.tag.col      = col_q;
    cmd_o.tag.first    = (pos_q == '0);
    cmd_o.tag.last_pos = pos_end;
    cmd_o.tag.last     = pos_end && col_end && row_end;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            smm_pkg::OP_LOAD_A: load_o.we_a = in_range;
            smm_pkg::OP_LOAD_B: load_o.we_b = in_range;
            smm_pkg::OP_START: begin
              state_d = ST_RUN;
              row_d   = '0;
              col_d   = '0;
              pos_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (advance_i) begin
          cmd_o.issue = 1'b1;
          if (!pos_end) begin
            pos_d = pos_q + smm_pkg::IDX_W'(1);
          end else begin
            pos_d = '0;
            if (!col_end) begin
              col_d = col_q + smm_pkg::IDX_W'(1);
            end else begin
              col_d = '0;
              row_d = row_q + smm_pkg::IDX_W'(1);
              if (row_end) begin
                state_d = ST_IDLE;
              end
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= MaxN;
      row_q   <= '0;
      col_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      row_q   <= row_d;
      col_q   <= col_d;
      pos_q   <= pos_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/smm_dp.sv -----
// Datapath: element stores, multiply-accumulate pipeline and output register.
`timescale 1ns / 1ps
`default_nettype none
module smm_dp #(
  parameter int MAX_SIZE = smm_pkg::MAX_SIZE_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  smm_pkg::cmd_t                       cmd_i,
  input  smm_pkg::load_t                      load_i,
  output logic                                advance_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [smm_pkg::OUT_DATA_W-1:0]      out_data_o,
  output logic                                out_last_o
);

  localparam int Depth = MAX_SIZE * MAX_SIZE;
  localparam int AddrW = $clog2(Depth);

  logic [AddrW-1:0]                 waddr, raddr_a, raddr_b;
  logic [smm_pkg::ELEM_W-1:0]       rdata_a, rdata_b;
  logic                             s1_valid_q, s2_valid_q, out_valid_q;
  smm_pkg::tag_t                    s1_tag_q, s2_tag_q;
  logic signed [smm_pkg::PROD_W-1:0] prod_q;
  logic signed [smm_pkg::ACC_W-1:0]  acc_q, sum;
  logic [smm_pkg::IDX_W-1:0]        out_row_q, out_col_q;
  logic signed [smm_pkg::ACC_W-1:0]  out_value_q;
  logic                             out_last_q;

  // The whole pipeline moves only when the output register can take a result.
  assign advance_o = !out_valid_q || out_ready_i;

  assign waddr   = AddrW'(load_i.row) * AddrW'(MAX_SIZE) + AddrW'(load_i.pos);
  assign raddr_a = AddrW'(cmd_i.tag.row) * AddrW'(MAX_SIZE) + AddrW'(cmd_i.pos);
  assign raddr_b = AddrW'(cmd_i.tag.col) * AddrW'(MAX_SIZE) + AddrW'(cmd_i.pos);

  smm_ram #(.WIDTH(smm_pkg::ELEM_W), .DEPTH(Depth)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (load_i.we_a),
    .waddr_i (waddr),
    .wdata_i (load_i.value),
    .re_i    (advance_o),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  smm_ram #(.WIDTH(smm_pkg::ELEM_W), .DEPTH(Depth)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (load_i.we_b),
    .waddr_i (waddr),
    .wdata_i (load_i.value),
    .re_i    (advance_o),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign sum = s2_tag_q.first ? smm_pkg::ACC_W'(prod_q)
                              : acc_q + smm_pkg::ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      s1_valid_q  <= cmd_i.issue;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q && s2_tag_q.last_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      s1_tag_q <= cmd_i.tag;
      s2_tag_q <= s1_tag_q;
      prod_q   <= $signed(rdata_a) * $signed(rdata_b);
      if (s2_valid_q) begin
        acc_q <= sum;
        if (s2_tag_q.last_pos) begin
          out_row_q   <= s2_tag_q.row;
          out_col_q   <= s2_tag_q.col;
          out_value_q <= sum;
          out_last_q  <= s2_tag_q.last;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {2'b00, out_value_q, out_col_q, out_row_q};

endmodule
`default_nettype wire

// ----- design/square_matrix_multiply.sv -----
// Top level of the square matrix multiplier.
// Loads and starts are taken one per cycle while idle.
// A start issues one multiply-accumulate per cycle unless the output stalls, n*n*n in all
// for size n, bound by the single read port of each element store; the last result
// passes the read data, product and output registers after the last issue.
// Reset clears control state and sets the size to the maximum; the stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module square_matrix_multiply #(
  parameter int MAX_SIZE = smm_pkg::MAX_SIZE_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // operation[1:0], row_index[4:2], col_index[7:5], element_value[23:8]
  input  wire logic [smm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // result_row[2:0], result_col[5:3], product_value[53:6], zeros[55:54]
  output logic [smm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_we_i,
  input  wire logic [smm_pkg::SIZE_W-1:0]     cfg_wdata_i
);

  smm_pkg::cmd_t              cmd;
  smm_pkg::load_t             load;
  logic                       advance;
  logic [smm_pkg::SIZE_W-1:0] size;

  smm_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .cmd_o       (cmd),
    .load_o      (load),
    .size_o      (size)
  );

  smm_dp #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .load_i      (load),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // The active size always stays within one and the maximum.
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size != '0 && size <= smm_pkg::SIZE_W'(MAX_SIZE))
    else $error("active size out of range");

  // A store write never shares a cycle with a read issue.
  a_no_load_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !(load.we_a || load.we_b))
    else $error("store write during multiply");

  // The last result beat is the bottom-right element.
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      {1'b0, m_axis_tdata[2:0]} == size - smm_pkg::SIZE_W'(1) &&
      {1'b0, m_axis_tdata[5:3]} == size - smm_pkg::SIZE_W'(1))
    else $error("last result is not the final element");

  // A read issue only happens in a cycle where the pipeline advances.
  a_issue_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> advance)
    else $error("issue without pipeline advance");

endmodule
`default_nettype wire
